### hw/rtl/itoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
package itoa_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned STEP_W     = 5;
	localparam int unsigned REM_W      = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	localparam logic [3:0] DIGIT_FIVE = 4'd5;
	localparam logic [3:0] DIGIT_NINE = 4'd9;
	localparam logic [3:0] DABBLE_ADJ = 4'd3;

	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(VALUE_W - 1);
	localparam logic [REM_W-1:0]  ALL_DIGITS = REM_W'(NUM_DIGITS);
	localparam logic [REM_W-1:0]  ONE_DIGIT  = REM_W'(1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

### hw/rtl/itoa_dabble.sv
// One double-dabble step: add-3 correction on every BCD digit, then shift in one bit.
module itoa_dabble import itoa_pkg::*; (
	input  logic [BCD_W-1:0] bcd_in,
	input  logic             bit_in,
	output logic [BCD_W-1:0] bcd_out
);

	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_in[4*i +: 4] >= DIGIT_FIVE) begin
				adj[4*i +: 4] = bcd_in[4*i +: 4] + DABBLE_ADJ;
			end else begin
				adj[4*i +: 4] = bcd_in[4*i +: 4];
			end
		end
	end

	// top bit of the top digit never carries for a 32-bit magnitude
	assign bcd_out = {adj[BCD_W-2:0], bit_in};

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
// Output order: the sign, if any, comes first, then one digit per cycle.
// Busy stays high through 32 conversion steps in the shared double-dabble unit, then a
//   leading-zero skip and emit pass over the 10 BCD digits, with the minus sign first for a
//   negative value; a new item is not taken until busy falls.
// Reset: arst_n clears the sequencer asynchronously; the block comes up idle, no strobe.
module signed_int_to_decimal_ascii import itoa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      strobe,
	output logic [7:0]                char_code,
	output logic                      last_char
);

	state_t             state_q;
	logic [VALUE_W-1:0] mag_q;     // magnitude, shifted out MSB first
	logic               neg_q;
	logic [BCD_W-1:0]   bcd_q;     // BCD digits, most significant in the top nibble
	logic [STEP_W-1:0]  step_q;    // conversion step counter
	logic [REM_W-1:0]   rem_q;     // digits still to skip or emit
	logic [BCD_W-1:0]   bcd_step;
	logic [3:0]         top_digit;
	logic               accept;

	// shared arithmetic unit, used once per conversion step
	itoa_dabble u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (mag_q[VALUE_W-1]),
		.bcd_out (bcd_step)
	);

	assign accept    = start && (state_q == ST_IDLE);
	assign top_digit = bcd_q[BCD_W-1 -: 4];

	// Sequencer. The negate is done in 32 bits: the most negative value yields
	// 0x80000000, which is its true magnitude read as unsigned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						step_q  <= '0;
						rem_q   <= ALL_DIGITS;
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, but always keep the last digit
					if (top_digit == 4'd0 && rem_q != ONE_DIGIT) begin
						rem_q <= rem_q - REM_W'(1);
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SIGN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					rem_q <= rem_q - REM_W'(1);
					if (rem_q == ONE_DIGIT) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					neg_q <= value[VALUE_W-1];
					mag_q <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_step;
				mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && rem_q != ONE_DIGIT) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			ST_EMIT: begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign char_code = (state_q == ST_SIGN) ? ASCII_MINUS : (ASCII_ZERO + {4'd0, top_digit});
	assign last_char = (state_q == ST_EMIT) && (rem_q == ONE_DIGIT);

	// Checks on the sequencer.
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_char) |=> !busy)
		else $error("busy after the last character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= DIGIT_NINE))
		else $error("BCD digit out of range");

	a_start_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe))
		else $error("accepted item did not start conversion");

	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> (neg_q && $past(state_q) == ST_SKIP))
		else $error("minus sign out of order");

endmodule
